### rtl/core/rpfq_pkg.sv
// Package: constants, types and codes for the remote page fault queues.
`timescale 1ns / 1ps
package rpfq_pkg;
	localparam int QUEUE_DEPTH = 64;
	localparam int REMOTE_BIT = 8;
	localparam logic [63:0] KEY_MASK = 64'h0000_FFFF_FFFF_FC00;
	localparam logic [63:0] LOW_BITS = 64'h0000_0000_0000_00FF;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_FAULT = 2'd2;
	localparam logic [1:0] OP_BAD = 2'd3;

	localparam logic [1:0] REG_FREE = 2'd0;
	localparam logic [1:0] REG_EVICT = 2'd1;
	localparam logic [1:0] REG_NEW = 2'd2;
	localparam logic [1:0] REG_BAD = 2'd3;

	localparam logic [1:0] COPY_NONE = 2'd0;
	localparam logic [1:0] COPY_SAVE = 2'd1;
	localparam logic [1:0] COPY_RESTORE = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;
	localparam logic [2:0] ST_BAD_REG = 3'd2;
	localparam logic [2:0] ST_REMOTE = 3'd3;
	localparam logic [2:0] ST_NO_FREE = 3'd4;
	localparam logic [2:0] ST_NO_MATCH = 3'd5;
	localparam logic [2:0] ST_FULL = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_FINISH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] reg_index;
		logic [63:0] write_value;
		logic [63:0] pte_word;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic pte_write;
		logic [63:0] pte_write_addr;
		logic [63:0] new_pte;
		logic [55:0] copy_frame;
		logic [1:0] copy_kind;
		logic [5:0] slot;
		logic [2:0] status;
	} rsp_t;

	function automatic logic [55:0] frame_of(input logic [63:0] pte);
		logic [63:0] p;
		p = pte & ~(64'd1 << REMOTE_BIT);
		return {p[53:10], 12'd0};
	endfunction
endpackage

### rtl/core/rpfq_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface rpfq_req_if;
	logic valid;
	logic ready;
	rpfq_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rpfq_rsp_if;
	logic valid;
	logic ready;
	rpfq_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/remote_page_fault_queues_unit.sv
// Top level: remote page fault queues with sequential evicted-table scan.
//  channel | dir | payload
//  req     | in  | op, reg_index, write_value, pte_word
//  rsp     | out | read_data, pte_write, pte_write_addr, new_pte, copy_frame,
//          |     | copy_kind, slot, status
// Evict and fault requests scan the evicted table one entry a cycle with a
// single compare unit; other requests go through a read state instead.
// Reset clears queue counts, valid bits and the age counter.
// One request at a time; req.ready is low until the response is taken.
`timescale 1ns / 1ps
module remote_page_fault_queues_unit #(
	parameter int QUEUE_DEPTH = rpfq_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	rpfq_req_if.sink req,
	rpfq_rsp_if.source rsp
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

	rpfq_pkg::state_t state_q, state_d;
	rpfq_pkg::req_t req_q;
	rpfq_pkg::rsp_t rsp_q, rsp_d;

	logic [55:0] free_mem [QUEUE_DEPTH];
	logic [63:0] evict_mem [QUEUE_DEPTH];
	logic [15:0] age_mem [QUEUE_DEPTH];
	logic [63:0] new_mem [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_q;

	logic [AW-1:0] fh_q, ft_q, nh_q, nt_q, idx_q;
	logic [CW-1:0] fc_q, nc_q;
	logic [15:0] age_q;

	logic [63:0] ev_rd_q;
	logic [15:0] ag_rd_q;
	logic [55:0] fr_rd_q;
	logic [63:0] nf_rd_q;
	logic rd_ok_q;
	logic [AW-1:0] rd_idx_q;

	logic found_q, best_ok_q;
	logic [AW-1:0] best_q, free_slot_q;
	logic [15:0] best_rel_q;
	logic [63:0] best_pte_q;
	logic scan_done;

	logic [15:0] rel;
	logic hit;
	logic [63:0] fault_pte;
	logic [63:0] evict_pte;

	assign req.ready = (state_q == rpfq_pkg::S_IDLE);
	assign rsp.valid = (state_q == rpfq_pkg::S_OUT);
	assign rsp.data = rsp_q;

	assign rel = age_q - ag_rd_q;
	assign hit = rd_ok_q && valid_q[rd_idx_q]
		&& ((ev_rd_q & rpfq_pkg::KEY_MASK) == (req_q.pte_word & rpfq_pkg::KEY_MASK));
	assign scan_done = !rd_ok_q && (idx_q == '0) && found_q;
	assign fault_pte = {10'd0, fr_rd_q[55:12], 10'd0} | (best_pte_q & rpfq_pkg::LOW_BITS);
	assign evict_pte = req_q.pte_word | (64'd1 << rpfq_pkg::REMOTE_BIT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpfq_pkg::S_IDLE: begin
				if (req.valid) begin
					if (req.data.op == rpfq_pkg::OP_FAULT
						|| (req.data.op == rpfq_pkg::OP_WRITE
						&& req.data.reg_index == rpfq_pkg::REG_EVICT))
						state_d = rpfq_pkg::S_SCAN;
					else
						state_d = rpfq_pkg::S_READ;
				end
			end
			rpfq_pkg::S_SCAN: if (scan_done) state_d = rpfq_pkg::S_FINISH;
			rpfq_pkg::S_READ: state_d = rpfq_pkg::S_FINISH;
			rpfq_pkg::S_FINISH: state_d = rpfq_pkg::S_OUT;
			rpfq_pkg::S_OUT: if (rsp.ready) state_d = rpfq_pkg::S_IDLE;
			default: state_d = rpfq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rpfq_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// memory reads, registered
	always_ff @(posedge clk) begin
		ev_rd_q <= evict_mem[idx_q];
		ag_rd_q <= age_mem[idx_q];
		fr_rd_q <= free_mem[fh_q];
		nf_rd_q <= new_mem[nh_q];
		rd_idx_q <= idx_q;
	end

	// scan sequencer and shared compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			found_q <= 1'b0;
			best_ok_q <= 1'b0;
			best_q <= '0;
			free_slot_q <= '0;
			best_rel_q <= '0;
		end else if (state_q == rpfq_pkg::S_IDLE) begin
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			found_q <= 1'b0;
			best_ok_q <= 1'b0;
		end else if (state_q == rpfq_pkg::S_SCAN) begin
			if (!found_q) begin
				rd_ok_q <= 1'b1;
				if (idx_q == LAST) begin
					idx_q <= '0;
					found_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else begin
				rd_ok_q <= 1'b0;
			end
			if (rd_ok_q) begin
				if (!valid_q[rd_idx_q] && !best_ok_q && req_q.op == rpfq_pkg::OP_WRITE) begin
					best_ok_q <= 1'b1;
					free_slot_q <= rd_idx_q;
				end
				if (hit && (!best_ok_q || rel > best_rel_q)
					&& req_q.op == rpfq_pkg::OP_FAULT) begin
					best_ok_q <= 1'b1;
					best_q <= rd_idx_q;
					best_rel_q <= rel;
					best_pte_q <= ev_rd_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) req_q <= req.data;
	end

	// response decode
	always_comb begin
		rsp_d = '0;
		case (req_q.op)
			rpfq_pkg::OP_WRITE: begin
				if (req_q.write_value == '0) begin
					rsp_d.status = rpfq_pkg::ST_ZERO;
				end else if (req_q.reg_index == rpfq_pkg::REG_FREE) begin
					if (fc_q == FULL_CNT) rsp_d.status = rpfq_pkg::ST_FULL;
				end else if (req_q.reg_index == rpfq_pkg::REG_EVICT) begin
					if (req_q.pte_word[rpfq_pkg::REMOTE_BIT]) begin
						rsp_d.status = rpfq_pkg::ST_REMOTE;
					end else if (!best_ok_q) begin
						rsp_d.status = rpfq_pkg::ST_FULL;
					end else begin
						rsp_d.pte_write = 1'b1;
						rsp_d.pte_write_addr = req_q.write_value;
						rsp_d.new_pte = evict_pte;
						rsp_d.copy_frame = rpfq_pkg::frame_of(req_q.pte_word);
						rsp_d.copy_kind = rpfq_pkg::COPY_SAVE;
						rsp_d.slot = 6'(free_slot_q);
					end
				end else begin
					rsp_d.status = rpfq_pkg::ST_BAD_REG;
				end
			end
			rpfq_pkg::OP_READ: begin
				case (req_q.reg_index)
					rpfq_pkg::REG_FREE: rsp_d.read_data = 64'(fc_q);
					rpfq_pkg::REG_EVICT: rsp_d.read_data = '0;
					rpfq_pkg::REG_NEW: begin
						if (nc_q != '0) rsp_d.read_data = nf_rd_q;
					end
					default: rsp_d.status = rpfq_pkg::ST_BAD_REG;
				endcase
			end
			rpfq_pkg::OP_FAULT: begin
				if (fc_q == '0) begin
					rsp_d.status = rpfq_pkg::ST_NO_FREE;
				end else if (!best_ok_q) begin
					rsp_d.status = rpfq_pkg::ST_NO_MATCH;
				end else if (nc_q == FULL_CNT) begin
					rsp_d.status = rpfq_pkg::ST_FULL;
				end else begin
					rsp_d.new_pte = fault_pte;
					rsp_d.copy_frame = fr_rd_q;
					rsp_d.copy_kind = rpfq_pkg::COPY_RESTORE;
					rsp_d.slot = 6'(best_q);
				end
			end
			default: rsp_d.status = rpfq_pkg::ST_BAD_REG;
		endcase
	end

	// result and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fh_q <= '0;
			ft_q <= '0;
			fc_q <= '0;
			nh_q <= '0;
			nt_q <= '0;
			nc_q <= '0;
			age_q <= '0;
		end else if (state_q == rpfq_pkg::S_FINISH) begin
			rsp_q <= rsp_d;
			if (req_q.op == rpfq_pkg::OP_WRITE && req_q.write_value != '0) begin
				if (req_q.reg_index == rpfq_pkg::REG_FREE && fc_q != FULL_CNT) begin
					free_mem[ft_q] <= rpfq_pkg::frame_of(req_q.pte_word);
					ft_q <= (ft_q == LAST) ? '0 : ft_q + 1'b1;
					fc_q <= fc_q + 1'b1;
				end
				if (req_q.reg_index == rpfq_pkg::REG_EVICT
					&& !req_q.pte_word[rpfq_pkg::REMOTE_BIT] && best_ok_q) begin
					evict_mem[free_slot_q] <= evict_pte;
					age_mem[free_slot_q] <= age_q;
					valid_q[free_slot_q] <= 1'b1;
					age_q <= age_q + 1'b1;
				end
			end
			if (req_q.op == rpfq_pkg::OP_READ && req_q.reg_index == rpfq_pkg::REG_NEW
				&& nc_q != '0) begin
				nh_q <= (nh_q == LAST) ? '0 : nh_q + 1'b1;
				nc_q <= nc_q - 1'b1;
			end
			if (req_q.op == rpfq_pkg::OP_FAULT && fc_q != '0 && best_ok_q
				&& nc_q != FULL_CNT) begin
				new_mem[nt_q] <= fault_pte;
				nt_q <= (nt_q == LAST) ? '0 : nt_q + 1'b1;
				nc_q <= nc_q + 1'b1;
				fh_q <= (fh_q == LAST) ? '0 : fh_q + 1'b1;
				fc_q <= fc_q - 1'b1;
				valid_q[best_q] <= 1'b0;
			end
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("request taken while response pending");
	a_fcnt: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FULL_CNT) else $error("free count overflow");
	a_ncnt: assert property (@(posedge clk) disable iff (!arst_n)
		nc_q <= FULL_CNT) else $error("new count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(rsp_q)) else $error("response changed");
endmodule

### tb/remote_page_fault_queues_unit_tb.sv
// Testbench: random and directed requests against a behavioral model of the page fault queues.
`timescale 1ns / 1ps
module remote_page_fault_queues_unit_tb;
	localparam int DEPTH = rpfq_pkg::QUEUE_DEPTH;
	localparam int N_KEYS = 6;

	typedef struct {
		rpfq_pkg::req_t rq;
		bit drain;
	} pending_t;

	logic clk;
	logic arst_n;
	rpfq_req_if req ();
	rpfq_rsp_if rsp ();

	remote_page_fault_queues_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// model state
	logic [55:0] free_q[$];
	logic [63:0] new_q[$];
	logic [63:0] evict_pte[DEPTH];
	bit evict_vld[DEPTH];
	logic [15:0] evict_age[DEPTH];
	logic [15:0] age_ctr;

	pending_t pending[$];
	rpfq_pkg::rsp_t expected_rsps[$];
	logic [63:0] keys[N_KEYS];
	int n_errors;
	int n_taken;
	int hold_cnt;
	int stall_cnt;
	bit taken;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("remote_page_fault_queues_unit: mismatch");
		$finish;
	end

	function automatic logic [55:0] frame_from_pte(logic [63:0] pte);
		logic [63:0] p;
		p = pte & ~(64'd1 << rpfq_pkg::REMOTE_BIT);
		p = (p >> 10) << 12;
		return p[55:0];
	endfunction

	function automatic rpfq_pkg::rsp_t predict_rsp(rpfq_pkg::req_t q);
		rpfq_pkg::rsp_t r;
		int s;
		int best;
		logic [15:0] rel;
		logic [15:0] best_rel;
		logic [63:0] np;
		logic [63:0] fr;
		r = '0;
		best_rel = '0;
		if (q.op == rpfq_pkg::OP_WRITE) begin
			if (q.write_value == 64'd0) r.status = rpfq_pkg::ST_ZERO;
			else if (q.reg_index == rpfq_pkg::REG_FREE) begin
				if (free_q.size() >= DEPTH) r.status = rpfq_pkg::ST_FULL;
				else free_q.push_back(frame_from_pte(q.pte_word));
			end else if (q.reg_index == rpfq_pkg::REG_EVICT) begin
				if (q.pte_word[rpfq_pkg::REMOTE_BIT]) r.status = rpfq_pkg::ST_REMOTE;
				else begin
					s = DEPTH;
					for (int i = DEPTH - 1; i >= 0; i--) if (!evict_vld[i]) s = i;
					if (s == DEPTH) r.status = rpfq_pkg::ST_FULL;
					else begin
						np = q.pte_word | (64'd1 << rpfq_pkg::REMOTE_BIT);
						evict_pte[s] = np;
						evict_vld[s] = 1'b1;
						evict_age[s] = age_ctr;
						age_ctr++;
						r.pte_write = 1'b1;
						r.pte_write_addr = q.write_value;
						r.new_pte = np;
						r.copy_frame = frame_from_pte(q.pte_word);
						r.copy_kind = rpfq_pkg::COPY_SAVE;
						r.slot = s[5:0];
					end
				end
			end else r.status = rpfq_pkg::ST_BAD_REG;
		end else if (q.op == rpfq_pkg::OP_READ) begin
			if (q.reg_index == rpfq_pkg::REG_FREE) r.read_data = 64'(free_q.size());
			else if (q.reg_index == rpfq_pkg::REG_NEW) begin
				if (new_q.size() > 0) r.read_data = new_q.pop_front();
			end else if (q.reg_index != rpfq_pkg::REG_EVICT) r.status = rpfq_pkg::ST_BAD_REG;
		end else if (q.op == rpfq_pkg::OP_FAULT) begin
			best = DEPTH;
			for (int i = 0; i < DEPTH; i++) begin
				if (evict_vld[i] && (evict_pte[i] & rpfq_pkg::KEY_MASK)
					== (q.pte_word & rpfq_pkg::KEY_MASK)) begin
					rel = age_ctr - evict_age[i];
					if (best == DEPTH || rel > best_rel) begin
						best = i;
						best_rel = rel;
					end
				end
			end
			if (free_q.size() == 0) r.status = rpfq_pkg::ST_NO_FREE;
			else if (best == DEPTH) r.status = rpfq_pkg::ST_NO_MATCH;
			else if (new_q.size() >= DEPTH) r.status = rpfq_pkg::ST_FULL;
			else begin
				fr = {8'd0, free_q.pop_front()};
				np = ((fr >> 12) << 10) | (evict_pte[best] & rpfq_pkg::LOW_BITS);
				evict_vld[best] = 1'b0;
				new_q.push_back(np);
				r.new_pte = np;
				r.copy_frame = fr[55:0];
				r.copy_kind = rpfq_pkg::COPY_RESTORE;
				r.slot = best[5:0];
			end
		end else r.status = rpfq_pkg::ST_BAD_REG;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("ERROR %t %s got %h expected %h", $realtime, what, got, want);
		n_errors++;
	endtask

	task automatic add(logic [1:0] op, logic [1:0] ri, logic [63:0] v, logic [63:0] p,
			bit drain = 1'b0);
		pending_t e;
		e.rq.op = op;
		e.rq.reg_index = ri;
		e.rq.write_value = v;
		e.rq.pte_word = p;
		e.drain = drain;
		pending.push_back(e);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] keyed_pte();
		return (keys[$urandom_range(N_KEYS - 1)] & rpfq_pkg::KEY_MASK)
			| (rand64() & ~rpfq_pkg::KEY_MASK);
	endfunction

	function automatic logic [63:0] nz64();
		logic [63:0] v;
		v = rand64();
		return (v == 0) ? 64'd1 : v;
	endfunction

	// phase of idling: 0 none, 1 sender idle, 2 receiver stall, 3 both
	function automatic int idle_phase();
		return (n_taken / 150) % 4;
	endfunction

	// driver
	always @(negedge clk) begin
		pending_t nxt;
		if (arst_n && !(req.valid && !taken)) begin
			taken <= 1'b0;
			if (pending.size() == 0) req.valid <= 1'b0;
			else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				req.valid <= 1'b0;
			end else if (pending[0].drain && expected_rsps.size() != 0) req.valid <= 1'b0;
			else if ((idle_phase() == 1 && $urandom_range(99) < 68) ||
					(idle_phase() == 3 && $urandom_range(99) < 10)) req.valid <= 1'b0;
			else begin
				nxt = pending.pop_front();
				req.data <= nxt.rq;
				req.valid <= 1'b1;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				rsp.ready <= 1'b0;
			end else if ((idle_phase() == 2 && $urandom_range(99) < 68) ||
					(idle_phase() == 3 && $urandom_range(99) < 10)) rsp.ready <= 1'b0;
			else rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (req.valid && req.ready) begin
			expected_rsps.push_back(predict_rsp(req.data));
			taken <= 1'b1;
			n_taken++;
			if (n_taken == 400 || n_taken == 1300) stall_cnt <= 600;
		end
	end

	// monitor
	always @(posedge clk) begin
		rpfq_pkg::rsp_t w;
		if (rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0)
				report("unexpected response", 64'(rsp.data.status), 64'd0);
			else begin
				w = expected_rsps.pop_front();
				if (rsp.data.read_data !== w.read_data)
					report("read_data", rsp.data.read_data, w.read_data);
				if (rsp.data.pte_write !== w.pte_write)
					report("pte_write", 64'(rsp.data.pte_write), 64'(w.pte_write));
				if (rsp.data.pte_write_addr !== w.pte_write_addr)
					report("pte_write_addr", rsp.data.pte_write_addr, w.pte_write_addr);
				if (rsp.data.new_pte !== w.new_pte)
					report("new_pte", rsp.data.new_pte, w.new_pte);
				if (rsp.data.copy_frame !== w.copy_frame)
					report("copy_frame", 64'(rsp.data.copy_frame), 64'(w.copy_frame));
				if (rsp.data.copy_kind !== w.copy_kind)
					report("copy_kind", 64'(rsp.data.copy_kind), 64'(w.copy_kind));
				if (rsp.data.slot !== w.slot)
					report("slot", 64'(rsp.data.slot), 64'(w.slot));
				if (rsp.data.status !== w.status)
					report("status", 64'(rsp.data.status), 64'(w.status));
			end
		end
	end

	initial begin
		int kind;
		int burst;
		n_errors = 0;
		n_taken = 0;
		hold_cnt = 0;
		stall_cnt = 0;
		taken = 1'b0;
		age_ctr = '0;
		for (int i = 0; i < DEPTH; i++) evict_vld[i] = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		for (int i = 0; i < N_KEYS; i++) keys[i] = rand64();
		keys[0] = '1;
		keys[1] = '0;

		// directed
		add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_FREE, 64'd0, '1);
		add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_NEW, '1, '1);
		add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_BAD, 64'd5, 64'd0);
		add(rpfq_pkg::OP_BAD, rpfq_pkg::REG_BAD, '1, '1);
		add(rpfq_pkg::OP_READ, rpfq_pkg::REG_FREE, '1, '1);
		add(rpfq_pkg::OP_READ, rpfq_pkg::REG_EVICT, 64'd0, 64'd0);
		add(rpfq_pkg::OP_READ, rpfq_pkg::REG_NEW, 64'd0, 64'd0);
		add(rpfq_pkg::OP_READ, rpfq_pkg::REG_BAD, 64'd0, 64'd0);
		add(rpfq_pkg::OP_FAULT, rpfq_pkg::REG_FREE, 64'd0, '1);
		add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_FREE, '1, '1);
		add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_FREE, 64'd1, 64'h0000_0000_0000_0400);
		add(rpfq_pkg::OP_FAULT, rpfq_pkg::REG_FREE, 64'd0, '1);
		add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_EVICT, '1, '1);
		add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_EVICT, '1, ~(64'd1 << rpfq_pkg::REMOTE_BIT));
		add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_EVICT, 64'd8,
			'1 & ~(64'd1 << rpfq_pkg::REMOTE_BIT) & ~64'hFF);
		add(rpfq_pkg::OP_FAULT, rpfq_pkg::REG_FREE, 64'd0, '1);
		add(rpfq_pkg::OP_READ, rpfq_pkg::REG_FREE, 64'd0, 64'd0);
		add(rpfq_pkg::OP_FAULT, rpfq_pkg::REG_FREE, 64'd0, 64'h0000_0000_0000_03FF);
		add(rpfq_pkg::OP_READ, rpfq_pkg::REG_NEW, 64'd0, 64'd0);
		add(rpfq_pkg::OP_READ, rpfq_pkg::REG_NEW, 64'd0, 64'd0);
		add(rpfq_pkg::OP_READ, rpfq_pkg::REG_NEW, 64'd0, 64'd0, 1'b1);

		// random
		while (pending.size() < 1850) begin
			kind = $urandom_range(99);
			burst = ($urandom_range(49) == 0) ? 70 : 1;
			for (int b = 0; b < burst; b++) begin
				if (kind < 24) add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_FREE, nz64(), rand64());
				else if (kind < 48)
					add(rpfq_pkg::OP_WRITE, rpfq_pkg::REG_EVICT, nz64(),
						keyed_pte() & ~(64'd1 << rpfq_pkg::REMOTE_BIT));
				else if (kind < 74)
					add(rpfq_pkg::OP_FAULT, 2'($urandom_range(3)), rand64(), keyed_pte());
				else if (kind < 88) add(rpfq_pkg::OP_READ, ($urandom_range(3) == 0) ?
						2'($urandom_range(3)) : rpfq_pkg::REG_NEW, rand64(), rand64());
				else if (kind < 92)
					add(rpfq_pkg::OP_WRITE, 2'($urandom_range(3)), 64'd0, rand64());
				else add(2'($urandom_range(3)), 2'($urandom_range(3)), rand64(), keyed_pte(),
						$urandom_range(30) == 0);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_taken >= 900);
		hold_cnt = 0;
		while (pending.size() != 0 || req.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (n_errors == 0) $display("remote_page_fault_queues_unit: match");
		else $display("remote_page_fault_queues_unit: mismatch");
		$finish;
	end
endmodule
